@@ rtl/positional_ordered_list_core_macros.svh @@
// assertion macros shared by the ordered list rtl
`ifndef POSITIONAL_ORDERED_LIST_CORE_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold on every rising clock edge outside reset
`define POL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pol assertion failed");
// implication checked on the cycle after the trigger
`define POL_ASSERT_NEXT(lbl, clk, rst, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("pol assertion failed");
`else
`define POL_ASSERT(lbl, clk, rst, prop)
`define POL_ASSERT_NEXT(lbl, clk, rst, trig, prop)
`endif

`endif

@@ rtl/pol_pkg.sv @@
// types and codes for the positional ordered list
`default_nettype none
package pol_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int COMMAND_W    = 3;
  localparam int POSITION_W   = 5;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;

  // commands
  localparam logic [COMMAND_W-1:0] CMD_PUSH_FRONT  = 3'd0;
  localparam logic [COMMAND_W-1:0] CMD_INSERT_AFTER = 3'd1;
  localparam logic [COMMAND_W-1:0] CMD_APPEND      = 3'd2;
  localparam logic [COMMAND_W-1:0] CMD_LENGTH      = 3'd3;
  localparam logic [COMMAND_W-1:0] CMD_DELETE      = 3'd4;
  localparam logic [COMMAND_W-1:0] CMD_DUMP        = 3'd5;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // cell operations broadcast along the chain
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_ROT  = 2'd3;

  typedef struct packed {
    logic [COMMAND_W-1:0]     command;
    logic [POSITION_W-1:0]    position;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic signed [VALUE_W-1:0] entry;
    logic                     last;
  } rsp_t;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/pol_cell.sv @@
// one storage cell of the list chain
`default_nettype none
module pol_cell #(
  parameter int CNT_W = 5,
  parameter int INDEX = 0
) (
  input  wire logic                              clk,
  input  wire pol_pkg::cell_ctrl_t               ctrl,
  input  wire logic [CNT_W-1:0]                  k,
  input  wire logic [CNT_W-1:0]                  lim,
  input  wire logic signed [pol_pkg::VALUE_W-1:0] left,
  input  wire logic signed [pol_pkg::VALUE_W-1:0] right,
  input  wire logic signed [pol_pkg::VALUE_W-1:0] head,
  output logic signed [pol_pkg::VALUE_W-1:0]      q
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic signed [pol_pkg::VALUE_W-1:0] q_next;

  always_comb begin
    q_next = q;
    unique case (ctrl.op)
      pol_pkg::OP_INS: begin
        if (MY_IDX == k) q_next = ctrl.value;
        else if (MY_IDX > k) q_next = left;
      end
      pol_pkg::OP_DEL: begin
        if (MY_IDX >= k) q_next = right;
      end
      pol_pkg::OP_ROT: begin
        // ring over the occupied cells, front wraps to the back
        if (MY_IDX == lim) q_next = head;
        else if (MY_IDX < lim) q_next = right;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
`default_nettype wire

@@ rtl/positional_ordered_list_core.sv @@
// positional ordered list: one command per transaction, results from a single output register
// results: valid in the cycle after the command; a dump's first entry goes via the dump state,
//   then the result register. throughput, while results are taken: one command per cycle, and
//   a dump streams one entry a cycle from cell 0, blocking commands until its last entry
// reset: synchronous, clears the count, the dump sequencer and the result valid; cells keep data
`default_nettype none
`include "positional_ordered_list_core_macros.svh"
module positional_ordered_list_core #(
  parameter int CAPACITY = pol_pkg::CAPACITY_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire pol_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output pol_pkg::rsp_t      rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > pol_pkg::POSITION_W) ? CNT_W : pol_pkg::POSITION_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic              state;
  logic              state_next;
  logic [CNT_W-1:0]  occ;
  logic [CNT_W-1:0]  occ_next;
  logic [CNT_W-1:0]  dcnt;
  logic [CNT_W-1:0]  dcnt_next;
  logic              emit;
  pol_pkg::rsp_t     rsp_next;

  pol_pkg::cell_ctrl_t ctrl;
  logic [CNT_W-1:0]    k;
  logic [CNT_W-1:0]    lim;
  logic signed [pol_pkg::VALUE_W-1:0] cell_q [CAPACITY];

  logic             slot_free;
  logic             cmd_fire;
  logic             pos_bad;
  logic             full;
  logic             dump_last;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] occ_c;

  assign slot_free = !rsp_valid || rsp_ready;
  assign cmd_ready = (state == S_IDLE) && slot_free;
  assign cmd_fire  = cmd_valid && cmd_ready;

  assign pos_c     = CMP_W'(cmd.position);
  assign occ_c     = CMP_W'(occ);
  assign pos_bad   = (pos_c == '0) || (pos_c > occ_c);
  assign full      = (occ == CAP_CNT);
  assign lim       = occ - CNT_W'(1);
  assign dump_last = (dcnt == lim);

  always_comb begin
    ctrl.op    = pol_pkg::OP_HOLD;
    ctrl.value = cmd.value;
    k          = '0;
    occ_next   = occ;
    state_next = state;
    dcnt_next  = dcnt;
    emit       = 1'b0;
    rsp_next.status = pol_pkg::ST_OK;
    rsp_next.entry  = '0;
    rsp_next.last   = 1'b1;
    if (cmd_fire) begin
      emit = 1'b1;
      unique case (cmd.command)
        pol_pkg::CMD_PUSH_FRONT: begin
          if (full) rsp_next.status = pol_pkg::ST_FULL;
          else begin
            ctrl.op  = pol_pkg::OP_INS;
            occ_next = occ + CNT_W'(1);
          end
        end
        pol_pkg::CMD_INSERT_AFTER: begin
          // position check comes before the full check
          if (pos_bad) rsp_next.status = pol_pkg::ST_BAD_POS;
          else if (full) rsp_next.status = pol_pkg::ST_FULL;
          else begin
            ctrl.op  = pol_pkg::OP_INS;
            k        = CNT_W'(cmd.position);
            occ_next = occ + CNT_W'(1);
          end
        end
        pol_pkg::CMD_APPEND: begin
          if (full) rsp_next.status = pol_pkg::ST_FULL;
          else begin
            ctrl.op  = pol_pkg::OP_INS;
            k        = occ;
            occ_next = occ + CNT_W'(1);
          end
        end
        pol_pkg::CMD_LENGTH: begin
        end
        pol_pkg::CMD_DELETE: begin
          if (pos_bad) rsp_next.status = pol_pkg::ST_BAD_POS;
          else begin
            ctrl.op  = pol_pkg::OP_DEL;
            k        = CNT_W'(cmd.position) - CNT_W'(1);
            occ_next = occ - CNT_W'(1);
          end
        end
        pol_pkg::CMD_DUMP: begin
          // empty list answers at once, otherwise stream from the front cell
          if (occ != '0) begin
            emit       = 1'b0;
            state_next = S_DUMP;
            dcnt_next  = '0;
          end
        end
        default: emit = 1'b0;
      endcase
    end else if ((state == S_DUMP) && slot_free) begin
      emit           = 1'b1;
      ctrl.op        = pol_pkg::OP_ROT;
      rsp_next.entry = cell_q[0];
      rsp_next.last  = dump_last;
      dcnt_next      = dcnt + CNT_W'(1);
      if (dump_last) state_next = S_IDLE;
    end
    rsp_next.count = pol_pkg::COUNT_W'(occ_next);
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [pol_pkg::VALUE_W-1:0] left_v;
      logic signed [pol_pkg::VALUE_W-1:0] right_v;
      if (gi == 0) begin : g_first
        assign left_v = cmd.value;
      end else begin : g_mid_l
        assign left_v = cell_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_end
        assign right_v = cell_q[gi];
      end else begin : g_mid_r
        assign right_v = cell_q[gi+1];
      end
      pol_cell #(
        .CNT_W (CNT_W),
        .INDEX (gi)
      ) u_cell (
        .clk   (clk),
        .ctrl  (ctrl),
        .k     (k),
        .lim   (lim),
        .left  (left_v),
        .right (right_v),
        .head  (cell_q[0]),
        .q     (cell_q[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      dcnt      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      dcnt  <= dcnt_next;
      if (emit) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) rsp <= rsp_next;
  end

  `POL_ASSERT(a_occ_bound, clk, rst, occ <= CAP_CNT)
  `POL_ASSERT(a_dump_in_range, clk, rst, (state == S_DUMP) |-> ((occ != '0) && (dcnt < occ)))
  `POL_ASSERT_NEXT(a_push_grows, clk, rst,
    cmd_fire && (cmd.command == pol_pkg::CMD_PUSH_FRONT) && !full,
    occ == $past(occ) + CNT_W'(1))
  `POL_ASSERT_NEXT(a_dump_keeps_count, clk, rst, state == S_DUMP, occ == $past(occ))

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// testbench for the positional ordered list core: directed table, then random bursts
`timescale 1ns / 1ps
module tb;

  localparam int LIST_CAP    = pol_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 360;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int CMD_W        = pol_pkg::COMMAND_W;
  localparam int POS_W        = pol_pkg::POSITION_W;
  localparam int VAL_W        = pol_pkg::VALUE_W;

  // codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

  typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_NOISE} stim_mode_t;

  typedef struct {
    pol_pkg::cmd_t c;
    bit            typed;
    pol_pkg::rsp_t exp;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic rsp_ready = 1'b0;
  pol_pkg::cmd_t cmd_bus = '0;
  logic cmd_ready;
  logic rsp_valid;
  pol_pkg::rsp_t rsp_bus;

  // typed expectation travelling alongside the command
  bit            row_typed = 1'b0;
  pol_pkg::rsp_t row_exp   = '0;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  int fail_count  = 0;
  int cycle_count = 0;
  int result_idx  = 0;

  // list contents as the block should hold them
  logic signed [VAL_W-1:0] list_cells [LIST_CAP];
  int   list_len = 0;
  pol_pkg::rsp_t pending_rsps [$];
  dir_row_t dir_rows [$];

  positional_ordered_list_core #(.CAPACITY(LIST_CAP)) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd_bus),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s at result %0d: got %0h, expected %0h",
             what, result_idx, got, want);
    fail_count++;
  endtask

  function automatic void place_value(input int idx, input logic signed [VAL_W-1:0] v);
    for (int i = list_len; i > idx; i--) list_cells[i] = list_cells[i-1];
    list_cells[idx] = v;
    list_len++;
  endfunction

  task automatic apply_list_cmd(input pol_pkg::cmd_t c, ref pol_pkg::rsp_t out_q[$]);
    pol_pkg::rsp_t r;
    r = '0;
    r.status = pol_pkg::ST_OK;
    r.last = 1'b1;
    case (c.command)
      pol_pkg::CMD_PUSH_FRONT: begin
        if (list_len >= LIST_CAP) r.status = pol_pkg::ST_FULL;
        else place_value(0, c.value);
      end
      pol_pkg::CMD_INSERT_AFTER: begin
        if (c.position == 0 || c.position > list_len) r.status = pol_pkg::ST_BAD_POS;
        else if (list_len >= LIST_CAP) r.status = pol_pkg::ST_FULL;
        else place_value(c.position, c.value);
      end
      pol_pkg::CMD_APPEND: begin
        if (list_len >= LIST_CAP) r.status = pol_pkg::ST_FULL;
        else place_value(list_len, c.value);
      end
      pol_pkg::CMD_LENGTH: ;
      pol_pkg::CMD_DELETE: begin
        if (c.position == 0 || c.position > list_len) begin
          r.status = pol_pkg::ST_BAD_POS;
        end else begin
          for (int i = c.position - 1; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      pol_pkg::CMD_DUMP: begin
        if (list_len != 0) begin
          for (int i = 0; i < list_len; i++) begin
            r.count = list_len[pol_pkg::COUNT_W-1:0];
            r.entry = list_cells[i];
            r.last = (i + 1 == list_len);
            out_q.push_back(r);
          end
          return;
        end
      end
      default: return;
    endcase
    r.count = list_len[pol_pkg::COUNT_W-1:0];
    out_q.push_back(r);
  endtask

  always @(posedge clk) begin : check_results
    pol_pkg::rsp_t want;
    pol_pkg::rsp_t new_q [$];
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_rsps.size() == 0) begin
          report_mismatch("unexpected result", rsp_bus.entry, '0);
        end else begin
          want = pending_rsps.pop_front();
          if (rsp_bus.status !== want.status)
            report_mismatch("status", rsp_bus.status, want.status);
          if (rsp_bus.count !== want.count)
            report_mismatch("count", rsp_bus.count, want.count);
          if (rsp_bus.entry !== want.entry)
            report_mismatch("entry", rsp_bus.entry, want.entry);
          if (rsp_bus.last !== want.last)
            report_mismatch("last", rsp_bus.last, want.last);
        end
        result_idx++;
      end
      if (cmd_valid && cmd_ready) begin
        new_q = {};
        apply_list_cmd(cmd_bus, new_q);
        if (row_typed) pending_rsps.push_back(row_exp);
        else foreach (new_q[i]) pending_rsps.push_back(new_q[i]);
      end
    end
  end

  function automatic bit idle_roll();
    return !calm && ($urandom_range(0, 99) < 32);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp_ready <= 1'b0;
      end else if (hold_req) begin
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          rsp_ready <= 1'b0;
          @(negedge clk);
        end
        hold_req = 1'b0;
        rsp_ready <= !idle_roll();
      end else begin
        rsp_ready <= !idle_roll();
      end
    end
  end

  // call just after a falling edge; returns at the accepting rising edge
  task automatic drive_cmd(input pol_pkg::cmd_t c, input bit typed, input pol_pkg::rsp_t exp);
    while (idle_roll()) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_bus   <= c;
    row_typed <= typed;
    row_exp   <= exp;
    do @(posedge clk); while (!cmd_ready);
  endtask

  task automatic drop_cmd_valid();
    @(negedge clk);
    cmd_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [CMD_W-1:0] op, input int pos,
                         input logic [VAL_W-1:0] val, input bit typed,
                         input logic [pol_pkg::STATUS_W-1:0] st, input int cnt);
    dir_row_t row;
    row.c.command  = op;
    row.c.position = pos[POS_W-1:0];
    row.c.value    = val;
    row.typed      = typed;
    row.exp        = '0;
    row.exp.status = st;
    row.exp.count  = cnt[pol_pkg::COUNT_W-1:0];
    row.exp.last   = 1'b1;
    dir_rows.push_back(row);
  endtask

  function automatic pol_pkg::cmd_t make_cmd(input stim_mode_t mode);
    pol_pkg::cmd_t c;
    int roll;
    c.value = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: c.value = 32'h8000_0000;
        1: c.value = 32'h7fff_ffff;
        2: c.value = '0;
        default: c.value = '1;
      endcase
    end
    c.position = POS_W'($urandom_range(0, 31));
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (roll < 30) c.command = pol_pkg::CMD_PUSH_FRONT;
        else if (roll < 60) c.command = pol_pkg::CMD_INSERT_AFTER;
        else if (roll < 90) c.command = pol_pkg::CMD_APPEND;
        else if (roll < 95) c.command = pol_pkg::CMD_LENGTH;
        else c.command = pol_pkg::CMD_DUMP;
      end
      MODE_SHRINK: begin
        if (roll < 75) c.command = pol_pkg::CMD_DELETE;
        else if (roll < 90) c.command = pol_pkg::CMD_DUMP;
        else c.command = pol_pkg::CMD_LENGTH;
      end
      MODE_MIXED: c.command = CMD_W'($urandom_range(pol_pkg::CMD_PUSH_FRONT, pol_pkg::CMD_DUMP));
      default: c.command = CMD_W'($urandom);
    endcase
    // mostly legal positions outside noise; sometimes one past the end
    if (mode != MODE_NOISE && list_len > 0 && $urandom_range(0, 99) < 80)
      c.position = POS_W'($urandom_range(1, list_len));
    else if (mode != MODE_NOISE && $urandom_range(0, 3) == 0)
      c.position = POS_W'(list_len + 1);
    // growing with a bad position would stall the fill
    if (mode == MODE_GROW && c.command == pol_pkg::CMD_INSERT_AFTER && list_len == 0)
      c.command = pol_pkg::CMD_APPEND;
    return c;
  endfunction

  initial begin : stimulus
    stim_mode_t mode;
    pol_pkg::cmd_t c;
    int items_sent;
    int burst;
    int burst_len;
    int pick;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_row(pol_pkg::CMD_LENGTH,       0,  32'h0,         1, pol_pkg::ST_OK,      0);
    add_row(pol_pkg::CMD_DUMP,         31, 32'hffff_ffff, 1, pol_pkg::ST_OK,      0);
    add_row(pol_pkg::CMD_DELETE,       1,  32'h0,         1, pol_pkg::ST_BAD_POS, 0);
    add_row(pol_pkg::CMD_INSERT_AFTER, 0,  32'h5,         1, pol_pkg::ST_BAD_POS, 0);
    add_row(pol_pkg::CMD_INSERT_AFTER, 1,  32'h5,         1, pol_pkg::ST_BAD_POS, 0);
    add_row(pol_pkg::CMD_PUSH_FRONT,   0,  32'h7fff_ffff, 1, pol_pkg::ST_OK,      1);
    add_row(pol_pkg::CMD_APPEND,       16, 32'h8000_0000, 1, pol_pkg::ST_OK,      2);
    add_row(pol_pkg::CMD_INSERT_AFTER, 2,  32'hffff_ffff, 1, pol_pkg::ST_OK,      3);
    add_row(pol_pkg::CMD_INSERT_AFTER, 1,  32'h0,         1, pol_pkg::ST_OK,      4);
    add_row(pol_pkg::CMD_INSERT_AFTER, 5,  32'h1,         1, pol_pkg::ST_BAD_POS, 4);
    add_row(pol_pkg::CMD_DELETE,       0,  32'h0,         1, pol_pkg::ST_BAD_POS, 4);
    add_row(pol_pkg::CMD_DELETE,       31, 32'h0,         1, pol_pkg::ST_BAD_POS, 4);
    add_row(CMD_UNDEF_LO,              1,  32'h1234_5678, 0, pol_pkg::ST_OK,      0);
    add_row(CMD_UNDEF_HI,              31, 32'hffff_ffff, 0, pol_pkg::ST_OK,      0);
    add_row(pol_pkg::CMD_DUMP,         0,  32'h0,         0, pol_pkg::ST_OK,      0);
    add_row(pol_pkg::CMD_DELETE,       4,  32'h0,         1, pol_pkg::ST_OK,      3);
    add_row(pol_pkg::CMD_DELETE,       1,  32'h0,         1, pol_pkg::ST_OK,      2);
    add_row(pol_pkg::CMD_LENGTH,       31, 32'h5555_aaaa, 1, pol_pkg::ST_OK,      2);
    add_row(pol_pkg::CMD_DUMP,         16, 32'haaaa_5555, 0, pol_pkg::ST_OK,      0);

    foreach (dir_rows[i]) begin
      @(negedge clk);
      drive_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].exp);
    end

    items_sent = 0;
    burst = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (burst == 0 || pick < 30) mode = MODE_GROW;
      else if (pick < 55) mode = MODE_SHRINK;
      else if (pick < 90) mode = MODE_MIXED;
      else mode = MODE_NOISE;
      // opening burst fills the list and runs into full
      burst_len = (burst == 0) ? 24 : $urandom_range(6, 30);
      if (burst == 2) hold_req = 1'b1;
      if (burst == 5) begin
        drop_cmd_valid();
        while (pending_rsps.size() != 0) @(posedge clk);
      end
      calm = (burst == 8 || burst == 9);
      for (int n = 0; n < burst_len; n++) begin
        @(negedge clk);
        c = make_cmd(mode);
        drive_cmd(c, 1'b0, '0);
        if (c.command <= pol_pkg::CMD_DUMP) items_sent++;
      end
      burst++;
    end
    calm = 1'b0;

    drop_cmd_valid();
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
